FILE: rtl/core/sisd_pkg.sv
package sisd_pkg;

    localparam int VALUE_W = 16;
    localparam int START_W = 4;
    localparam int COUNT_W = 5;
    localparam int ADDR_W  = 6;
    localparam int SEG_W   = 14;
    localparam int QUOT_W  = 12;
    localparam int MAX_DIGITS = 5;

    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd8;

    // n / 10 == (n * 52429) >> 19 for every 16-bit n
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef logic [3:0] char_t;

    localparam char_t CHAR_MINUS = 4'd10;

    function automatic logic [15:0] glyph(input char_t code);
        logic [15:0] g;
        case (code)
            4'd0:       g = 16'hE49C;
            4'd1:       g = 16'h0408;
            4'd2:       g = 16'hC30C;
            4'd3:       g = 16'h870C;
            4'd4:       g = 16'h0788;
            4'd5:       g = 16'h8784;
            4'd6:       g = 16'hC784;
            4'd7:       g = 16'h040C;
            4'd8:       g = 16'hC78C;
            4'd9:       g = 16'h078C;
            CHAR_MINUS: g = 16'h0300;
            default:    g = 16'h0000;
        endcase
        return g;
    endfunction

    // Drop the two low bits of the font pattern, then reverse the 14 left.
    function automatic logic [SEG_W-1:0] segments(input char_t code);
        logic [15:0]      g;
        logic [SEG_W-1:0] src;
        logic [SEG_W-1:0] dst;
        g   = glyph(code);
        src = g[15:2];
        for (int b = 0; b < SEG_W; b++)
        begin
            dst[SEG_W-1-b] = src[b];
        end
        return dst;
    endfunction

endpackage

FILE: rtl/core/sisd_div10.sv
module sisd_div10
    import sisd_pkg::*;
(
    input  logic [VALUE_W-1:0] mag,
    output logic [QUOT_W-1:0]  quot,
    output char_t              rem
);

    logic [31:0]        product;
    logic [31:0]        shifted;
    logic [VALUE_W-1:0] tens;

    assign product = 32'(mag) * 32'(DIV10_RECIP);
    assign shifted = product >> DIV10_SHIFT;
    assign quot    = shifted[QUOT_W-1:0];
    assign tens    = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem     = 4'(mag - tens);

endmodule

FILE: rtl/core/signed_int_to_segment_digits.sv
// Converts a signed 16-bit value to segment-display characters, most
// significant first, a minus sign leading a negative value. An accepted
// request first runs through one shared divide-by-ten unit, one decimal digit
// per cycle, then issues one character per cycle into the output register
// whenever that register is free, skipping characters that land at or past the
// active digit count. in_ready stays low until the last character has been
// handed to the output register, or until conversion ends if no character is
// visible. digit_count (reset 8) is written through the cfg channel, which is
// always ready, and is clamped to DIGIT_CAPACITY.
module signed_int_to_segment_digits
    import sisd_pkg::*;
#(
    parameter int DIGIT_CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [COUNT_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] number_value,
    input  logic [START_W-1:0]        start_position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_W-1:0]         ram_address,
    output logic [SEG_W-1:0]          segment_bits,
    output logic                      last_char
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  digit_count_reg, digit_count_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic                neg_reg, neg_next;
    logic [2:0]          nd_reg, nd_next;
    logic [2:0]          left_reg, left_next;
    logic [5:0]          pos_reg, pos_next;
    char_t               digit_reg [MAX_DIGITS];
    char_t               digit_next [MAX_DIGITS];

    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic                last_reg, last_next;

    logic [QUOT_W-1:0]   quot;
    char_t               rem;
    logic [5:0]          limit;
    logic [5:0]          avail;
    logic [2:0]          nchars;
    logic [2:0]          nvis;
    logic [5:0]          diff;
    logic                slot_free;
    char_t               cur_char;

    sisd_div10 u_div10 (
        .mag  (mag_reg),
        .quot (quot),
        .rem  (rem)
    );

    assign limit = ({1'b0, digit_count_reg} > 6'(DIGIT_CAPACITY)) ?
                   6'(DIGIT_CAPACITY) : {1'b0, digit_count_reg};

    // Characters after this conversion step: digits so far plus sign.
    assign nchars = nd_reg + 3'd1 + {2'b00, neg_reg};
    assign avail  = (limit > {2'b00, start_reg}) ? (limit - {2'b00, start_reg}) : 6'd0;
    assign nvis   = (avail < {3'b000, nchars}) ? avail[2:0] : nchars;

    assign slot_free = !out_valid_reg || out_ready;
    assign cur_char  = neg_reg ? CHAR_MINUS : digit_reg[0];
    assign diff      = limit - 6'd1 - pos_reg;

    always_comb
    begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        mag_next         = mag_reg;
        start_next       = start_reg;
        neg_next         = neg_reg;
        nd_next          = nd_reg;
        left_next        = left_reg;
        pos_next         = pos_reg;
        digit_next       = digit_reg;
        out_valid_next   = out_valid_reg;
        addr_next        = addr_reg;
        seg_next         = seg_reg;
        last_next        = last_reg;

        if (cfg_valid)
        begin
            digit_count_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = number_value[VALUE_W-1];
                    mag_next   = number_value[VALUE_W-1] ?
                                 (16'd0 - 16'(number_value)) : 16'(number_value);
                    start_next = start_position;
                    nd_next    = 3'd0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Prepend each remainder so the front ends up most significant.
                digit_next[0] = rem;
                for (int i = 1; i < MAX_DIGITS; i++)
                begin
                    digit_next[i] = digit_reg[i-1];
                end
                mag_next = 16'(quot);
                nd_next  = nd_reg + 3'd1;
                if (quot == '0)
                begin
                    left_next  = nvis;
                    pos_next   = {2'b00, start_reg};
                    state_next = (nvis == 3'd0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = diff + {diff[4:0], 1'b0};
                    seg_next       = segments(cur_char);
                    last_next      = (left_reg == 3'd1);
                    if (neg_reg)
                    begin
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_DIGITS - 1; i++)
                        begin
                            digit_next[i] = digit_reg[i+1];
                        end
                    end
                    pos_next  = pos_reg + 6'd1;
                    left_next = left_reg - 3'd1;
                    if (left_reg == 3'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            digit_count_reg <= DIGIT_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            neg_reg         <= 1'b0;
            nd_reg          <= 3'd0;
            left_reg        <= 3'd0;
            pos_reg         <= 6'd0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            out_valid_reg   <= out_valid_next;
            neg_reg         <= neg_next;
            nd_reg          <= nd_next;
            left_reg        <= left_next;
            pos_reg         <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        start_reg <= start_next;
        digit_reg <= digit_next;
        addr_reg  <= addr_next;
        seg_reg   <= seg_next;
        last_reg  <= last_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign ram_address  = addr_reg;
    assign segment_bits = seg_reg;
    assign last_char    = last_reg;

endmodule
